// ===== design/intrusion_alarm_controller_macros.svh =====
// assertion macros shared by the intrusion alarm controller modules
`ifndef INTRUSION_ALARM_CONTROLLER_MACROS_SVH
`define INTRUSION_ALARM_CONTROLLER_MACROS_SVH

// same-cycle implication, checked outside reset
`define IAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define IAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/iac_pkg.sv =====
// types, codes and reset values for the intrusion alarm controller
package iac_pkg;

    localparam int TIME_BITS = 32;
    localparam int CFG_BITS  = 16;
    localparam int IDX_BITS  = 2;
    localparam int CMD_BITS  = 3;

    // command codes, codes above CMD_RESET act as no command
    localparam logic [CMD_BITS-1:0] CMD_NONE   = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_ARM    = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_DISARM = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_STATUS = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_RESET  = 3'd4;

    // intrusion cause codes
    localparam logic [1:0] CAUSE_NONE   = 2'd0;
    localparam logic [1:0] CAUSE_DOOR   = 2'd1;
    localparam logic [1:0] CAUSE_MOTION = 2'd2;

    // configuration register indexes
    localparam logic [IDX_BITS-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_COOLDOWN = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_BEEP     = 2'd2;

    // configuration reset values
    localparam logic [CFG_BITS-1:0] DEBOUNCE_RST = 16'd40;
    localparam logic [CFG_BITS-1:0] COOLDOWN_RST = 16'd3000;
    localparam logic [CFG_BITS-1:0] BEEP_RST     = 16'd200;

    typedef struct packed {
        logic [TIME_BITS-1:0] now_ms;
        logic                 door_raw;
        logic                 pir_raw;
        logic [CMD_BITS-1:0]  command;
    } t_in_item;

    typedef struct packed {
        logic       buzzer;
        logic       armed;
        logic       alarm_active;
        logic       door_open;
        logic       motion_event;
        logic [1:0] intrusion_cause;
        logic       status_valid;
        logic       pir_level;
    } t_res_item;

endpackage

// ===== design/iac_if.sv =====
// channel interfaces: polling input, result output, configuration write

interface iac_in_if import iac_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] now_ms;
    logic                 door_raw;
    logic                 pir_raw;
    logic [CMD_BITS-1:0]  command;

    modport source (output valid, output now_ms, output door_raw, output pir_raw,
                    output command, input ready);
    modport sink   (input valid, input now_ms, input door_raw, input pir_raw,
                    input command, output ready);
endinterface

interface iac_res_if;
    logic       valid;
    logic       ready;
    logic       buzzer;
    logic       armed;
    logic       alarm_active;
    logic       door_open;
    logic       motion_event;
    logic [1:0] intrusion_cause;
    logic       status_valid;
    logic       pir_level;

    modport source (output valid, output buzzer, output armed, output alarm_active,
                    output door_open, output motion_event, output intrusion_cause,
                    output status_valid, output pir_level, input ready);
    modport sink   (input valid, input buzzer, input armed, input alarm_active,
                    input door_open, input motion_event, input intrusion_cause,
                    input status_valid, input pir_level, output ready);
endinterface

interface iac_cfg_if import iac_pkg::*;;
    logic                valid;
    logic                ready;
    logic [IDX_BITS-1:0] index;
    logic [CFG_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/iac_in_reg.sv =====
// input register stage that captures one polling transaction
module iac_in_reg import iac_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    iac_in_if.sink   i_in,
    input  logic     i_down_ready,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     accept;

    // take a new transaction when empty or when the held one moves on
    assign i_in.ready = !r_valid || i_down_ready;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= '{now_ms:   i_in.now_ms,
                        door_raw: i_in.door_raw,
                        pir_raw:  i_in.pir_raw,
                        command:  i_in.command};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== design/iac_step.sv =====
// alarm state, configuration registers and the per-step update logic
`include "intrusion_alarm_controller_macros.svh"

module iac_step import iac_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iac_cfg_if.sink   i_cfg,
    input  logic      i_valid,
    input  t_in_item  i_item,
    input  logic      i_down_ready,
    output logic      o_valid,
    output t_res_item o_res
);

    // configuration registers
    logic [CFG_BITS-1:0]  r_debounce;
    logic [CFG_BITS-1:0]  r_cooldown;
    logic [CFG_BITS-1:0]  r_beep_ms;

    // alarm state
    logic                 r_armed;
    logic                 r_alarm;
    logic                 r_door_last;
    logic                 r_door_stable;
    logic [TIME_BITS-1:0] r_door_time;
    logic [TIME_BITS-1:0] r_motion_time;
    logic [TIME_BITS-1:0] r_beep_time;
    logic                 r_beep_level;

    logic                 n_armed;
    logic                 n_alarm;
    logic                 n_door_stable;
    logic [TIME_BITS-1:0] n_door_time;
    logic [TIME_BITS-1:0] n_motion_time;
    logic [TIME_BITS-1:0] n_beep_time;
    logic                 n_beep_level;

    logic                 status;
    logic                 motion;
    logic [1:0]           cause;
    logic [TIME_BITS-1:0] door_elapsed;
    logic [TIME_BITS-1:0] motion_elapsed;
    logic [TIME_BITS-1:0] beep_elapsed;
    logic                 fire;

    assign fire        = i_valid && i_down_ready;
    assign i_cfg.ready = 1'b1;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_cooldown <= COOLDOWN_RST;
            r_beep_ms  <= BEEP_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_DEBOUNCE: r_debounce <= i_cfg.data;
                REG_COOLDOWN: r_cooldown <= i_cfg.data;
                REG_BEEP:     r_beep_ms  <= i_cfg.data;
                default:      ;
            endcase
        end
    end

    // one polling step: command, door debounce, motion cooldown, raise, beep
    always_comb begin
        n_armed       = r_armed;
        n_alarm       = r_alarm;
        n_beep_level  = r_beep_level;
        n_door_stable = r_door_stable;
        n_motion_time = r_motion_time;
        n_beep_time   = r_beep_time;
        status        = 1'b0;
        motion        = 1'b0;
        cause         = CAUSE_NONE;

        unique case (i_item.command)
            CMD_ARM: begin
                n_armed = 1'b1;
            end
            CMD_DISARM: begin
                n_armed      = 1'b0;
                n_alarm      = 1'b0;
                n_beep_level = 1'b0;
            end
            CMD_STATUS: begin
                status = 1'b1;
            end
            CMD_RESET: begin
                n_alarm      = 1'b0;
                n_beep_level = 1'b0;
            end
            default: ;
        endcase

        // a raw edge restarts the debounce window
        n_door_time  = (i_item.door_raw != r_door_last) ? i_item.now_ms : r_door_time;
        door_elapsed = i_item.now_ms - n_door_time;
        if (door_elapsed > TIME_BITS'(r_debounce)) begin
            n_door_stable = i_item.door_raw;
        end

        motion_elapsed = i_item.now_ms - r_motion_time;
        if (i_item.pir_raw && (motion_elapsed > TIME_BITS'(r_cooldown))) begin
            n_motion_time = i_item.now_ms;
            motion        = 1'b1;
        end

        // door takes precedence over motion
        if (n_armed && !n_alarm) begin
            priority if (n_door_stable) begin
                n_alarm = 1'b1;
                cause   = CAUSE_DOOR;
            end else if (motion) begin
                n_alarm = 1'b1;
                cause   = CAUSE_MOTION;
            end
        end

        beep_elapsed = i_item.now_ms - r_beep_time;
        if (n_alarm && (beep_elapsed >= TIME_BITS'(r_beep_ms))) begin
            n_beep_time  = i_item.now_ms;
            n_beep_level = !n_beep_level;
        end
    end

    // state update on each step that moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed       <= 1'b1;
            r_alarm       <= 1'b0;
            r_door_last   <= 1'b1;
            r_door_stable <= 1'b1;
            r_door_time   <= '0;
            r_motion_time <= '0;
            r_beep_time   <= '0;
            r_beep_level  <= 1'b0;
        end else if (fire) begin
            r_armed       <= n_armed;
            r_alarm       <= n_alarm;
            r_door_last   <= i_item.door_raw;
            r_door_stable <= n_door_stable;
            r_door_time   <= n_door_time;
            r_motion_time <= n_motion_time;
            r_beep_time   <= n_beep_time;
            r_beep_level  <= n_beep_level;
        end
    end

    assign o_valid = i_valid;
    assign o_res   = '{buzzer:          n_beep_level,
                       armed:           n_armed,
                       alarm_active:    n_alarm,
                       door_open:       n_door_stable,
                       motion_event:    motion,
                       intrusion_cause: cause,
                       status_valid:    status,
                       pir_level:       i_item.pir_raw};

    // buzzer only sounds with the alarm on
    `IAC_ASSERT_NOW(a_buzz_needs_alarm, i_clk, i_rst_n, r_beep_level, r_alarm)
    // a raise cause implies the alarm is on in that result
    `IAC_ASSERT_NOW(a_cause_alarm, i_clk, i_rst_n,
                    i_valid && (o_res.intrusion_cause != CAUSE_NONE), o_res.alarm_active)
    // a disarm that moves on leaves the system disarmed and silent
    `IAC_ASSERT_NEXT(a_disarm, i_clk, i_rst_n, fire && (i_item.command == CMD_DISARM),
                     !r_armed && !r_alarm && !r_beep_level)

endmodule

// ===== design/iac_out_reg.sv =====
// result register that drives the output channel
module iac_out_reg import iac_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_res_item i_res,
    output logic      o_ready,
    iac_res_if.source o_res
);

    logic      r_valid;
    t_res_item r_res;

    assign o_ready = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid           = r_valid;
    assign o_res.buzzer          = r_res.buzzer;
    assign o_res.armed           = r_res.armed;
    assign o_res.alarm_active    = r_res.alarm_active;
    assign o_res.door_open       = r_res.door_open;
    assign o_res.motion_event    = r_res.motion_event;
    assign o_res.intrusion_cause = r_res.intrusion_cause;
    assign o_res.status_valid    = r_res.status_valid;
    assign o_res.pir_level       = r_res.pir_level;

endmodule

// ===== design/intrusion_alarm_controller.sv =====
// top level of the intrusion alarm controller
//
//   port     role      transaction
//   i_in     sink      one polling step: now_ms, door_raw, pir_raw, command
//   o_res    source    one result per step: buzzer, flags, door, motion, cause, status
//   i_cfg    sink      register write: index and 16-bit data, always ready
//
// one step per clock while the result side takes results; a step is taken into the input register,
// then goes through the update logic into the result register, from which it can leave
// the throughput is bounded by the alarm state update loop
// i_rst_n is synchronous: config returns to 40/3000/200, armed, door open
// a stalled result holds in the result register while the input register
// can still take one more step if it is empty

module intrusion_alarm_controller import iac_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iac_in_if.sink    i_in,
    iac_res_if.source o_res,
    iac_cfg_if.sink   i_cfg
);

    logic      in_valid;
    t_in_item  in_item;
    logic      step_valid;
    t_res_item step_res;
    logic      out_ready;

    iac_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_down_ready (out_ready),
        .o_valid      (in_valid),
        .o_item       (in_item)
    );

    iac_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_valid      (in_valid),
        .i_item       (in_item),
        .i_down_ready (out_ready),
        .o_valid      (step_valid),
        .o_res        (step_res)
    );

    iac_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (step_valid),
        .i_res   (step_res),
        .o_ready (out_ready),
        .o_res   (o_res)
    );

endmodule

// ===== test/tb_intrusion_alarm_controller.sv =====
`timescale 1ns / 100ps
// testbench for the intrusion alarm controller: random polling steps checked by a step predictor
module tb_intrusion_alarm_controller;
    import iac_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 4;
    localparam int STEPS_PER_PHASE = 100;
    localparam int NUM_PHASES      = 5;
    localparam int MAX_REPORTS     = 10;
    localparam int TIMEOUT_NS      = 4_000_000;

    // register index past the end of the map, writes must be ignored
    localparam logic [IDX_BITS-1:0] REG_UNUSED = 2'd3;
    // spare command codes that behave as no command
    localparam logic [CMD_BITS-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_SPARE_LAST  = 3'd7;

    // step predictor plus the queue of results it still owes
    class alarm_tracker;
        logic [CFG_BITS-1:0]  debounce_ms;
        logic [CFG_BITS-1:0]  cooldown_ms;
        logic [CFG_BITS-1:0]  beep_half_ms;
        logic                 armed;
        logic                 alarm;
        logic                 door_last;
        logic                 door_stable;
        logic                 beep_level;
        logic [TIME_BITS-1:0] door_change_ms;
        logic [TIME_BITS-1:0] motion_ms;
        logic [TIME_BITS-1:0] beep_toggle_ms;
        t_res_item            owed_results[$];
        int                   steps;
        int                   compared;
        int                   mismatches;
        int                   orphans;
        int                   door_alarms;
        int                   motion_alarms;
        int                   status_reports;
        int                   reg_writes;

        function new();
            debounce_ms    = DEBOUNCE_RST;
            cooldown_ms    = COOLDOWN_RST;
            beep_half_ms   = BEEP_RST;
            armed          = 1'b1;
            alarm          = 1'b0;
            door_last      = 1'b1;
            door_stable    = 1'b1;
            beep_level     = 1'b0;
            door_change_ms = '0;
            motion_ms      = '0;
            beep_toggle_ms = '0;
        endfunction

        function void write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
            reg_writes++;
            case (idx)
                REG_DEBOUNCE: debounce_ms = data;
                REG_COOLDOWN: cooldown_ms = data;
                REG_BEEP:     beep_half_ms = data;
                default: ;
            endcase
        endfunction

        // one polling step: command, door debounce, motion cooldown, raise, beep
        function void note_step(t_in_item step);
            t_res_item            want;
            logic [TIME_BITS-1:0] gap_ms;
            want = '0;
            steps++;
            case (step.command)
                CMD_ARM: armed = 1'b1;
                CMD_DISARM: begin
                    armed      = 1'b0;
                    alarm      = 1'b0;
                    beep_level = 1'b0;
                end
                CMD_STATUS: want.status_valid = 1'b1;
                CMD_RESET: begin
                    alarm      = 1'b0;
                    beep_level = 1'b0;
                end
                default: ;
            endcase

            if (step.door_raw != door_last) begin
                door_last      = step.door_raw;
                door_change_ms = step.now_ms;
            end
            gap_ms = step.now_ms - door_change_ms;
            if (gap_ms > debounce_ms)
                door_stable = step.door_raw;

            gap_ms = step.now_ms - motion_ms;
            if (step.pir_raw && gap_ms > cooldown_ms) begin
                motion_ms         = step.now_ms;
                want.motion_event = 1'b1;
            end

            // door takes priority over motion
            if (armed && !alarm) begin
                if (door_stable) begin
                    alarm                = 1'b1;
                    want.intrusion_cause = CAUSE_DOOR;
                    door_alarms++;
                end else if (want.motion_event) begin
                    alarm                = 1'b1;
                    want.intrusion_cause = CAUSE_MOTION;
                    motion_alarms++;
                end
            end

            gap_ms = step.now_ms - beep_toggle_ms;
            if (alarm && gap_ms >= beep_half_ms) begin
                beep_toggle_ms = step.now_ms;
                beep_level     = ~beep_level;
            end

            if (want.status_valid)
                status_reports++;
            want.buzzer       = beep_level;
            want.armed        = armed;
            want.alarm_active = alarm;
            want.door_open    = door_stable;
            want.pir_level    = step.pir_raw;
            owed_results.push_back(want);
        endfunction

        function string fmt(t_res_item r);
            return $sformatf({"buzzer=%b armed=%b alarm=%b door=%b ",
                              "motion=%b cause=%0d status=%b pir=%b"},
                             r.buzzer, r.armed, r.alarm_active, r.door_open, r.motion_event,
                             r.intrusion_cause, r.status_valid, r.pir_level);
        endfunction

        function void check_result(t_res_item got);
            t_res_item want;
            if (owed_results.size() == 0) begin
                orphans++;
                if (mismatches + orphans <= MAX_REPORTS)
                    $display("%0t: result with nothing owed: %s", $realtime, fmt(got));
                return;
            end
            want = owed_results.pop_front();
            compared++;
            // any field that differs or carries x fails the transaction
            if (got.buzzer !== want.buzzer || got.armed !== want.armed ||
                got.alarm_active !== want.alarm_active || got.door_open !== want.door_open ||
                got.motion_event !== want.motion_event ||
                got.intrusion_cause !== want.intrusion_cause ||
                got.status_valid !== want.status_valid || got.pir_level !== want.pir_level) begin
                mismatches++;
                if (mismatches + orphans <= MAX_REPORTS) begin
                    $display("%0t: mismatch on result %0d", $realtime, compared);
                    $display("    expected %s", fmt(want));
                    $display("    actual   %s", fmt(got));
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    iac_in_if  in_ch ();
    iac_res_if res_ch ();
    iac_cfg_if cfg_ch ();

    intrusion_alarm_controller dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    alarm_tracker         tracker;
    logic [TIME_BITS-1:0] wall_ms;
    logic                 door_lvl;
    int                   cfg_now [3];
    int                   burst_left;
    int                   rx_run;
    int                   rx_hold;
    bit                   tx_steady;
    bit                   rx_steady;

    // clock
    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // result side stalls: runs of ready, then short holds
    always @(negedge clk) begin
        if (rx_steady) begin
            res_ch.ready <= 1'b1;
        end else if (rx_run > 0) begin
            res_ch.ready <= 1'b1;
            rx_run--;
        end else if (rx_hold > 0) begin
            res_ch.ready <= 1'b0;
            rx_hold--;
        end else begin
            rx_run  = $urandom_range(0, 12);
            rx_hold = $urandom_range(1, 5);
            res_ch.ready <= 1'b0;
        end
    end

    // transaction monitors on the rising edge
    always @(posedge clk) begin
        if (rst_n && in_ch.valid && in_ch.ready)
            tracker.note_step(t_in_item'{in_ch.now_ms, in_ch.door_raw, in_ch.pir_raw,
                                         in_ch.command});
        if (rst_n && res_ch.valid && res_ch.ready)
            tracker.check_result(t_res_item'{res_ch.buzzer, res_ch.armed, res_ch.alarm_active,
                                             res_ch.door_open, res_ch.motion_event,
                                             res_ch.intrusion_cause, res_ch.status_valid,
                                             res_ch.pir_level});
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
            tracker.write_reg(cfg_ch.index, cfg_ch.data);
    end

    // one polling step, sent in bursts with random gaps between them unless tx_steady is set
    task automatic send_step(input logic [TIME_BITS-1:0] now, input logic door,
                             input logic pir, input logic [CMD_BITS-1:0] cmd);
        if (!tx_steady && burst_left == 0) begin
            repeat ($urandom_range(1, 6)) begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        in_ch.valid    <= 1'b1;
        in_ch.now_ms   <= now;
        in_ch.door_raw <= door;
        in_ch.pir_raw  <= pir;
        in_ch.command  <= cmd;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // wait for every owed result, then let the bench settle
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (tracker.owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_timing(input int debounce, input int cooldown, input int beep);
        drain();
        write_cfg(REG_DEBOUNCE, CFG_BITS'(debounce));
        write_cfg(REG_COOLDOWN, CFG_BITS'(cooldown));
        write_cfg(REG_BEEP, CFG_BITS'(beep));
        cfg_now[0] = debounce;
        cfg_now[1] = cooldown;
        cfg_now[2] = beep;
    endtask

    // time advance: mostly small, often near a threshold, now and then a wild jump
    function automatic logic [TIME_BITS-1:0] pick_delta();
        int pick;
        int limit;
        pick  = $urandom_range(0, 99);
        limit = cfg_now[$urandom_range(0, 2)];
        if (pick < 55)
            return $urandom_range(0, 3);
        if (pick < 78)
            return $urandom_range(0, limit);
        if (pick < 96)
            return limit + $urandom_range(0, 2) - 1;
        return $urandom();
    endfunction

    function automatic logic [CMD_BITS-1:0] pick_cmd();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 68) return CMD_NONE;
        if (pick < 75) return CMD_ARM;
        if (pick < 80) return CMD_DISARM;
        if (pick < 88) return CMD_STATUS;
        if (pick < 94) return CMD_RESET;
        return CMD_BITS'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    endfunction

    // disarm with the door shut, let it settle, arm, then watch for intrusions
    task automatic armed_episode();
        door_lvl = 1'b0;
        wall_ms += pick_delta();
        send_step(wall_ms, 1'b0, 1'b0, CMD_DISARM);
        wall_ms += cfg_now[0] + 1;
        send_step(wall_ms, 1'b0, 1'b0, CMD_NONE);
        wall_ms += pick_delta();
        send_step(wall_ms, 1'b0, 1'($urandom_range(0, 1)), CMD_ARM);
        repeat ($urandom_range(4, 14)) begin
            wall_ms += pick_delta();
            if ($urandom_range(0, 9) == 0)
                door_lvl = ~door_lvl;
            send_step(wall_ms, door_lvl, $urandom_range(0, 99) < 40, pick_cmd());
        end
    endtask

    task automatic noise_steps();
        repeat ($urandom_range(1, 6)) begin
            wall_ms += pick_delta();
            send_step(wall_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      CMD_BITS'($urandom_range(CMD_NONE, CMD_SPARE_LAST)));
        end
    endtask

    // stimulus
    initial begin
        int phase_goal;
        tracker = new();
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.now_ms    = '0;
        in_ch.door_raw  = 1'b0;
        in_ch.pir_raw   = 1'b0;
        in_ch.command   = CMD_NONE;
        res_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_DEBOUNCE;
        cfg_ch.data     = '0;
        cfg_now[0]      = DEBOUNCE_RST;
        cfg_now[1]      = COOLDOWN_RST;
        cfg_now[2]      = BEEP_RST;
        burst_left      = 0;
        rx_run          = 0;
        rx_hold         = 0;
        tx_steady       = 1'b0;
        rx_steady       = 1'b0;
        door_lvl        = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed steps with reset timing
        send_step(32'd0, 1'b1, 1'b0, CMD_NONE);          // armed power-up, door reads open
        send_step(32'd10, 1'b1, 1'b1, CMD_NONE);         // motion too close to time zero
        send_step(32'd200, 1'b1, 1'b0, CMD_STATUS);      // first buzzer toggle
        send_step(32'd250, 1'b0, 1'b0, CMD_RESET);       // reset, door still reads open
        send_step(32'd251, 1'b0, 1'b0, CMD_DISARM);
        send_step(32'd400, 1'b0, 1'b0, CMD_NONE);        // door settles closed
        send_step(32'd3001, 1'b0, 1'b1, CMD_ARM);        // motion raises the alarm
        send_step(32'd3002, 1'b0, 1'b1, CMD_NONE);       // inside cooldown
        send_step(32'd3100, 1'b0, 1'b0, CMD_SPARE_FIRST);
        send_step(32'd3150, 1'b1, 1'b0, CMD_SPARE_MID);
        send_step(32'd3200, 1'b1, 1'b1, CMD_SPARE_LAST);
        send_step(32'd3300, 1'b1, 1'b0, CMD_RESET);      // door open long enough
        send_step(32'hFFFF_FFF0, 1'b0, 1'b1, CMD_DISARM);
        send_step(32'hFFFF_FFFF, 1'b0, 1'b0, CMD_NONE);
        send_step(32'h0000_0030, 1'b0, 1'b0, CMD_ARM);   // elapsed time across the wrap
        send_step(32'h0000_0031, 1'b0, 1'b1, CMD_NONE);
        send_step(32'h8000_0000, 1'b1, 1'b1, CMD_STATUS);
        send_step(32'h7FFF_FFFF, 1'b0, 1'b0, CMD_NONE);  // time runs backwards
        send_step(32'hAAAA_AAAA, 1'b1, 1'b1, CMD_ARM);
        send_step(32'h5555_5555, 1'b0, 1'b1, CMD_RESET);
        wall_ms = 32'h5555_5555;

        // random episodes, one register setting per phase
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                1: begin
                    set_timing(0, 0, 0);                  // zero beep toggles every step
                    write_cfg(REG_UNUSED, 16'hFFFF);
                end
                2: set_timing(3, 10, 2);
                3: set_timing(65535, 65535, 65535);
                4: set_timing($urandom_range(0, 300), $urandom_range(0, 300),
                              $urandom_range(1, 300));
                default: ;
            endcase
            tx_steady  = (phase == 2);
            rx_steady  = (phase == 2);
            phase_goal = tracker.steps + STEPS_PER_PHASE;
            while (tracker.steps < phase_goal) begin
                if ($urandom_range(0, 9) < 7)
                    armed_episode();
                else
                    noise_steps();
            end
        end

        drain();
        $display("covered %0d polling steps over %0d register settings, %0d register writes",
                 tracker.steps, NUM_PHASES, tracker.reg_writes);
        $display("compared %0d results: %0d door alarms, %0d motion alarms, %0d status reports",
                 tracker.compared, tracker.door_alarms, tracker.motion_alarms,
                 tracker.status_reports);
        if (tracker.mismatches == 0 && tracker.orphans == 0 &&
            tracker.owed_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d unexpected results", tracker.mismatches,
                     tracker.orphans);
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results still owed", tracker.owed_results.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
